/* src/stq_pkg.sv */
// Shared types, codes and defaults for the sorted timer queue.
package stq_pkg;

	// Default sizing
	localparam int DEPTH_DEF      = 16;
	localparam int EVENT_BITS_DEF = 8;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed field widths of the stream payloads
	localparam int KIND_W   = 2;
	localparam int EV_W     = 8;
	localparam int DUR_W    = 30;
	localparam int RM_W     = 5;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 16;

	// Input item kinds
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

	// Result kinds
	localparam logic [KIND_W-1:0] RES_EXPIRED  = 2'd0;
	localparam logic [KIND_W-1:0] RES_ACCEPTED = 2'd1;
	localparam logic [KIND_W-1:0] RES_FULL     = 2'd2;
	localparam logic [KIND_W-1:0] RES_STOPPED  = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_EXPIRE,
		ST_PACK,
		ST_STOP_EMIT
	} stq_state_t;

endpackage

/* src/stq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module stq_ram
	import stq_pkg::*;
#(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/sorted_timer_queue.sv */
// Sorted timer queue: top level with sequencer, scan unit and result register.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | tuser kind; tdata event_id, duration
//  m_axis   | out | tuser result_kind; tdata expired_event, removed_count; tlast
//
// Start stores one entry unless the store is full. Stop removes matching entries in one compacting pass.
// A tick makes one pass per expired entry plus one more; every pass walks the entry RAM
// through its single read port into one subtract and compare unit.
// A full result register stalls the sequencer; s_axis_tready is high only when idle.
// Reset clears the time counter and the entry count; the entry RAM needs no clearing.
module sorted_timer_queue
	import stq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int EVENT_BITS = EVENT_BITS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // [7:0] event_id, [37:8] duration, [39:38] zero
	input  logic [KIND_W-1:0]   s_axis_tuser,  // [1:0] kind
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // [7:0] expired_event, [12:8] removed_count
	output logic [KIND_W-1:0]   m_axis_tuser,  // [1:0] result_kind
	output logic                m_axis_tlast
);

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int ENTRY_W = TIME_BITS + EVENT_BITS;
	localparam logic [TIME_BITS-1:0] SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

	stq_state_t state_q, state_d;

	// Control registers
	logic [TIME_BITS-1:0] now_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rd_q;
	logic [CW-1:0]        wr_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        rm_q;
	logic                 stop_mode_q;
	logic                 best_vld_q;
	logic [DEPTH-1:0]     removed_q;
	logic                 vld_s1;
	logic                 m_valid_q;

	// Payload registers
	logic [EVENT_BITS-1:0] ev_q;
	logic [DUR_W-1:0]      dur_q;
	logic [TIME_BITS-1:0]  best_key_q;
	logic [AW-1:0]         best_idx_q;
	logic [EVENT_BITS-1:0] best_ev_q;
	logic [AW-1:0]         idx_s1;
	logic [KIND_W-1:0]     out_kind_q;
	logic [EV_W-1:0]       out_ev_q;
	logic [RM_W-1:0]       out_rm_q;
	logic                  out_last_q;

	// RAM ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               issue_rd;
	logic [ENTRY_W-1:0] ram_rdata;

	// Emit request
	logic              emit;
	logic [KIND_W-1:0] emit_kind;
	logic [EV_W-1:0]   emit_ev;
	logic [RM_W-1:0]   emit_rm;
	logic              emit_last;

	logic s_fire, out_free, pass_end, full;

	// Scan unit signals
	logic [TIME_BITS-1:0]  due_s1, diff_s1, key_s1;
	logic [EVENT_BITS-1:0] ev_s1;
	logic                  hit_s1, drop_s1;

	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign pass_end = (rd_q == count_q) && !vld_s1;
	assign full     = (count_q == CW'(DEPTH));

	// Entry RAM
	stq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue_rd),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Shared subtract and compare on the entry just read
	always_comb begin
		due_s1  = ram_rdata[TIME_BITS-1:0];
		ev_s1   = ram_rdata[ENTRY_W-1 -: EVENT_BITS];
		diff_s1 = due_s1 - now_q;
		key_s1  = diff_s1 ^ SIGN;
		hit_s1  = ((diff_s1 == '0) || diff_s1[TIME_BITS-1]) && !removed_q[idx_s1];
		drop_s1 = stop_mode_q ? (ev_s1 == ev_q) : removed_q[idx_s1];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					case (s_axis_tuser)
						KIND_TICK:  state_d = ST_SCAN;
						KIND_START: state_d = ST_START;
						KIND_STOP:  state_d = ST_PACK;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_START: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (pass_end) state_d = ST_EXPIRE;
			end
			ST_EXPIRE: begin
				if (cnt_q == '0) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					state_d = (cnt_q == CW'(1)) ? ST_PACK : ST_SCAN;
				end
			end
			ST_PACK: begin
				if (pass_end) state_d = stop_mode_q ? ST_STOP_EMIT : ST_IDLE;
			end
			ST_STOP_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		issue_rd      = ((state_q == ST_SCAN) || (state_q == ST_PACK)) && (rd_q < count_q);
		ram_we        = 1'b0;
		ram_waddr     = wr_q[AW-1:0];
		ram_wdata     = ram_rdata;
		emit          = 1'b0;
		emit_kind     = RES_EXPIRED;
		emit_ev       = EV_W'(ev_q);
		emit_rm       = '0;
		emit_last     = 1'b1;
		case (state_q)
			ST_START: begin
				emit      = out_free;
				emit_kind = full ? RES_FULL : RES_ACCEPTED;
				ram_we    = out_free && !full;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = {ev_q, now_q + TIME_BITS'(dur_q)};
			end
			ST_EXPIRE: begin
				emit      = out_free && (cnt_q != '0);
				emit_kind = RES_EXPIRED;
				emit_ev   = EV_W'(best_ev_q);
				emit_last = (cnt_q == CW'(1));
			end
			ST_PACK: begin
				ram_we = vld_s1 && !drop_s1;
			end
			ST_STOP_EMIT: begin
				emit      = out_free;
				emit_kind = RES_STOPPED;
				emit_rm   = RM_W'(rm_q);
			end
			default: ;
		endcase
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			count_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			cnt_q       <= '0;
			rm_q        <= '0;
			stop_mode_q <= 1'b0;
			best_vld_q  <= 1'b0;
			removed_q   <= '0;
			vld_s1      <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue_rd;
			if (issue_rd) rd_q <= rd_q + CW'(1);

			// Result register handshake
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						stop_mode_q <= (s_axis_tuser == KIND_STOP);
						rd_q        <= '0;
						wr_q        <= '0;
						cnt_q       <= '0;
						rm_q        <= '0;
						best_vld_q  <= 1'b0;
						if (s_axis_tuser == KIND_TICK) now_q <= now_q + TIME_BITS'(1);
					end
				end
				ST_START: begin
					if (ram_we) count_q <= count_q + CW'(1);
				end
				ST_SCAN: begin
					if (vld_s1 && hit_s1) begin
						cnt_q <= cnt_q + CW'(1);
						if (!best_vld_q || (key_s1 < best_key_q)) best_vld_q <= 1'b1;
					end
				end
				ST_EXPIRE: begin
					if (emit) begin
						removed_q[best_idx_q] <= 1'b1;
						rd_q       <= '0;
						cnt_q      <= '0;
						best_vld_q <= 1'b0;
					end
				end
				ST_PACK: begin
					if (vld_s1) begin
						if (drop_s1) begin
							rm_q <= rm_q + CW'(1);
						end else begin
							wr_q <= wr_q + CW'(1);
						end
					end
					if (pass_end) begin
						count_q   <= wr_q;
						removed_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[AW-1:0];
		if (s_fire) begin
			ev_q  <= EVENT_BITS'(s_axis_tdata[EV_W-1:0]);
			dur_q <= s_axis_tdata[EV_W +: DUR_W];
		end
		if ((state_q == ST_SCAN) && vld_s1 && hit_s1 &&
		    (!best_vld_q || (key_s1 < best_key_q))) begin
			best_key_q <= key_s1;
			best_idx_q <= idx_s1;
			best_ev_q  <= ev_s1;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_ev_q   <= emit_ev;
			out_rm_q   <= emit_rm;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(M_DATA_W-EV_W-RM_W){1'b0}}, out_rm_q, out_ev_q};

`ifndef SYNTHESIS
	// Store never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// A new result is only loaded when the register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwritten while waiting");

	// Compaction never writes ahead of the entry being read
	a_pack_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PACK && vld_s1) |-> (wr_q <= CW'(idx_s1)))
		else $error("compaction write overtook read");

	// Removal marks are all cleared once the block is idle
	a_marks_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (removed_q == '0))
		else $error("removal marks left behind");
`endif

endmodule

/* sim/tb_sorted_timer_queue.sv */
// Self-checking testbench for the sorted timer queue: stream driver, monitor and predictor.
module tb_sorted_timer_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import stq_pkg::*;

	localparam int DEPTH   = DEPTH_DEF;
	localparam int TIME_W  = TIME_BITS_DEF;
	localparam int N_ITEMS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 500;
	localparam int STALL_LIMIT = 5000;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [DUR_W-1:0]  DUR_MAX     = {DUR_W{1'b1}};

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [EV_W-1:0]   ev;
		logic [DUR_W-1:0]  dur;
		bit                drain_first;  // wait for all results before offering
		bit                hold_rx;      // receiver holds off once this is taken
	} timer_cmd_t;

	typedef struct {
		logic [KIND_W-1:0] rkind;
		logic [EV_W-1:0]   ev;
		logic [RM_W-1:0]   removed;
		logic              last;
	} timer_result_t;

	// DUT connections
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;  // [7:0] event_id, [37:8] duration, [39:38] zero
	logic [KIND_W-1:0]   s_axis_tuser = '0;  // [1:0] kind
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;       // [7:0] expired_event, [12:8] removed_count
	logic [KIND_W-1:0]   m_axis_tuser;       // [1:0] result_kind
	logic                m_axis_tlast;

	// Stimulus and expected results
	timer_cmd_t    timer_cmds[$];
	timer_cmd_t    cur_cmd;
	timer_result_t awaited_results[$];
	int n_items = 0;
	int calm_from = 0;
	int issued_n = 0;    // input beats taken by the block
	int put_n = 0;       // results predicted
	int got_n = 0;       // results received
	int mismatches = 0;
	int idle_cycles = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	bit rx_hold_req = 1'b0;
	bit rx_hold_done = 1'b0;

	// Stimulus build state
	int n_real = 0;
	bit drain_next = 1'b0;
	bit hold_next = 1'b0;

	// Predictor state
	logic [TIME_W-1:0] now_ticks = '0;
	int                store_n = 0;
	logic [TIME_W-1:0] store_due[DEPTH];
	logic [EV_W-1:0]   store_ev[DEPTH];

	sorted_timer_queue uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #10 clk = ~clk;

	function automatic void push_result(logic [KIND_W-1:0] rk, logic [EV_W-1:0] ev,
			int removed, bit last);
		timer_result_t r;
		r.rkind   = rk;
		r.ev      = ev;
		r.removed = removed[RM_W-1:0];
		r.last    = last;
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	// Apply one accepted command to the timer store; returns the number of results
	function automatic int apply_timer_cmd(timer_cmd_t c);
		logic signed [TIME_W-1:0] lag[DEPTH];
		bit hit[DEPTH];
		bit gone[DEPTH];
		int n_hit;
		int best;
		int j;
		int removed;
		n_hit = 0;
		j = 0;
		removed = 0;
		case (c.kind)
			KIND_START: begin
				if (store_n >= DEPTH) begin
					push_result(RES_FULL, c.ev, 0, 1'b1);
				end else begin
					store_due[store_n] = now_ticks + TIME_W'(c.dur);
					store_ev[store_n]  = c.ev;
					store_n++;
					push_result(RES_ACCEPTED, c.ev, 0, 1'b1);
				end
				return 1;
			end
			KIND_STOP: begin
				for (int k = 0; k < store_n; k++) begin
					if (store_ev[k] == c.ev) begin
						removed++;
					end else begin
						store_due[j] = store_due[k];
						store_ev[j]  = store_ev[k];
						j++;
					end
				end
				store_n = j;
				push_result(RES_STOPPED, c.ev, removed, 1'b1);
				return 1;
			end
			KIND_TICK: begin
				now_ticks = now_ticks + 1'b1;
				// due at or before now: signed distance to now is zero or negative
				for (int k = 0; k < DEPTH; k++) begin
					hit[k]  = 1'b0;
					gone[k] = 1'b0;
					lag[k]  = '0;
				end
				for (int k = 0; k < store_n; k++) begin
					lag[k] = store_due[k] - now_ticks;
					hit[k] = (lag[k] <= 0);
					if (hit[k])
						n_hit++;
				end
				// earliest due first, ties to the older entry
				for (int n = 0; n < n_hit; n++) begin
					best = -1;
					for (int k = 0; k < store_n; k++)
						if (hit[k] && (best < 0 || lag[k] < lag[best]))
							best = k;
					hit[best]  = 1'b0;
					gone[best] = 1'b1;
					push_result(RES_EXPIRED, store_ev[best], 0, n == n_hit - 1);
				end
				for (int k = 0; k < store_n; k++) begin
					if (!gone[k]) begin
						store_due[j] = store_due[k];
						store_ev[j]  = store_ev[k];
						j++;
					end
				end
				store_n = j;
				return n_hit;
			end
			default: return 0;  // unused kind is ignored
		endcase
	endfunction

	// Driver: offers queued commands, with random gaps
	always @(posedge clk or negedge arst_n) begin
		int made;
		made = 0;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				made = apply_timer_cmd(cur_cmd);
				issued_n <= issued_n + 1;
				put_n    <= put_n + made;
				if (cur_cmd.hold_rx)
					rx_hold_req <= 1'b1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (timer_cmds.size() != 0 &&
						!(timer_cmds[0].drain_first && put_n + made != got_n)) begin
					cur_cmd = timer_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= cur_cmd.kind;
					s_axis_tdata  <= {2'b00, cur_cmd.dur, cur_cmd.ev};
					if (issued_n < calm_from && $urandom_range(0, 3) == 0)
						tx_gap = $urandom_range(1, 16);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks result beats and drives back-pressure
	always @(posedge clk or negedge arst_n) begin
		timer_result_t got;
		timer_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.rkind   = m_axis_tuser;
				got.ev      = m_axis_tdata[7:0];
				got.removed = m_axis_tdata[12:8];
				got.last    = m_axis_tlast;
				got_n <= got_n + 1;
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: unexpected beat kind %0d ev %0d removed %0d last %0b",
							got.rkind, got.ev, got.removed, got.last);
				end else begin
					want = awaited_results.pop_front();
					if (got.rkind !== want.rkind || got.ev !== want.ev ||
							got.removed !== want.removed || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp kind %0d ev %0d removed %0d last %0b, ",
								"got kind %0d ev %0d removed %0d last %0b"},
								want.rkind, want.ev, want.removed, want.last,
								got.rkind, got.ev, got.removed, got.last);
					end
				end
			end
			// one long hold-off, plus random stall bursts before the calm tail
			if (rx_hold_req && !rx_hold_done) begin
				rx_hold_done = 1'b1;
				rx_stall = HOLD_CYCLES;
			end
			if (rx_stall != 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (issued_n < calm_from && $urandom_range(0, 4) == 0)
					rx_stall = $urandom_range(1, 16);
			end
		end
	end

	// Watchdog: no beat moving on either side for too long while work remains
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else if (issued_n != n_items || put_n != got_n)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", idle_cycles);
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic add_cmd(logic [KIND_W-1:0] kind, logic [EV_W-1:0] ev,
			logic [DUR_W-1:0] dur);
		timer_cmd_t c;
		c.kind        = kind;
		c.ev          = ev;
		c.dur         = dur;
		c.drain_first = drain_next;
		c.hold_rx     = hold_next;
		drain_next = 1'b0;
		hold_next  = 1'b0;
		timer_cmds.insert(timer_cmds.size(), c);
		if (kind != KIND_UNUSED)
			n_real++;
	endtask

	// Mostly a small id pool so that stops find their entries
	function automatic logic [EV_W-1:0] pick_id();
		if ($urandom_range(0, 4) != 0)
			return EV_W'($urandom_range(0, 7));
		return EV_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [DUR_W-1:0] pick_dur();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 85)
			return DUR_W'($urandom_range(0, 24));
		if (sel < 95)
			return DUR_W'($urandom_range(0, 200));
		return DUR_W'($urandom());
	endfunction

	task automatic add_burst(int n_start, logic [DUR_W-1:0] dur, bit hold);
		for (int k = 0; k < n_start; k++)
			add_cmd(KIND_START, pick_id(), dur);
		for (int k = 0; k <= int'(dur); k++) begin
			hold_next = hold && (k == int'(dur));
			add_cmd(KIND_TICK, '0, '0);
		end
	endtask

	initial begin
		int sel;
		bit hold_placed;
		bit drain_placed;
		hold_placed  = 1'b0;
		drain_placed = 1'b0;

		// Directed: empty store, ignored kind, long timer, full store, ties
		add_cmd(KIND_TICK, 8'hFF, DUR_MAX);
		add_cmd(KIND_STOP, 8'h00, '0);
		add_cmd(KIND_UNUSED, 8'hFF, DUR_MAX);
		add_cmd(KIND_START, 8'hFF, DUR_MAX);
		for (int k = 0; k < DEPTH - 1; k++)
			add_cmd(KIND_START, EV_W'(k % 5), DUR_W'((k * 3) % 5));
		add_cmd(KIND_START, 8'hAA, '0);
		add_cmd(KIND_STOP, 8'h02, '0);
		for (int k = 0; k < 4; k++)
			add_cmd(KIND_TICK, '0, '0);
		add_cmd(KIND_STOP, 8'hFF, '0);

		// Random: single commands mixed with fill-and-expire bursts
		drain_next = 1'b1;
		while (n_real < N_ITEMS) begin
			if (!hold_placed && n_real >= 150) begin
				hold_placed = 1'b1;
				add_burst(DEPTH, '0, 1'b1);
			end else begin
				if (!drain_placed && n_real >= 220) begin
					drain_placed = 1'b1;
					drain_next = 1'b1;
				end
				sel = $urandom_range(0, 99);
				if (sel < 6)
					add_burst($urandom_range(4, DEPTH + 1), DUR_W'($urandom_range(0, 3)), 1'b0);
				else if (sel < 45)
					add_cmd(KIND_TICK, EV_W'($urandom()), DUR_W'($urandom()));
				else if (sel < 78)
					add_cmd(KIND_START, pick_id(), pick_dur());
				else if (sel < 95)
					add_cmd(KIND_STOP, pick_id(), DUR_W'($urandom()));
				else
					add_cmd(KIND_UNUSED, EV_W'($urandom()), DUR_W'($urandom()));
			end
		end
		n_items   = timer_cmds.size();
		calm_from = n_items - 40;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (!(issued_n == n_items && put_n == got_n))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("tb: success");
		end else begin
			if (awaited_results.size() != 0)
				$display("%0d expected results never arrived", awaited_results.size());
			$display("%0d mismatches", mismatches);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/stq_pkg.sv
src/stq_ram.sv
src/sorted_timer_queue.sv
sim/tb_sorted_timer_queue.sv
